// ----- design/assert_macros.svh -----
// Shared concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, idle while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lfsc_pkg.sv -----
`default_nettype none

package lfsc_pkg;

  localparam int CHANNELS  = 5;
  localparam int BUF_DEPTH = 256;
  localparam int NBUF      = 2 * CHANNELS;
  localparam int MEM_DEPTH = NBUF * BUF_DEPTH;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int BUF_W     = (NBUF > 1) ? $clog2(NBUF) : 1;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PEEK_N    = 6;

  typedef logic [7:0]        byte_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [PTR_W:0]    cnt1_t;
  typedef logic [BUF_W-1:0]  buf_idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // operation codes
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // sentence classes
  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_GGA     = 4'd1;
  localparam logic [3:0] CLS_GSA     = 4'd2;
  localparam logic [3:0] CLS_GSV     = 4'd3;
  localparam logic [3:0] CLS_RMC     = 4'd4;
  localparam logic [3:0] CLS_VTG     = 4'd5;
  localparam logic [3:0] CLS_PGRMZ   = 4'd6;
  localparam logic [3:0] CLS_PMTK    = 4'd7;
  localparam logic [3:0] CLS_PSCSO   = 4'd8;
  localparam logic [3:0] CLS_PSCSW   = 4'd9;
  localparam logic [3:0] CLS_UNKNOWN = 4'd10;
  localparam logic [3:0] CLS_OK      = 4'd11;

  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_DOLLAR = 8'h24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       direction;
    logic [2:0] channel;
    logic [1:0] func;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [3:0] head_class;
    logic [7:0] line_count;
    logic [7:0] byte_count;
    logic       is_empty;
    logic [7:0] popped_byte;
  } result_t;

  function automatic ptr_t next_pos(input ptr_t p);
    return (p == ptr_t'(BUF_DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

  function automatic addr_t mem_addr(input buf_idx_t b, input ptr_t p);
    return addr_t'(addr_t'(b) * addr_t'(BUF_DEPTH) + addr_t'(p));
  endfunction

  function automatic logic [7:0] sat8(input ptr_t v);
    return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
  endfunction

  // hdr holds the six peeked bytes, first byte in the low bits
  function automatic logic [3:0] classify(input logic [47:0] hdr);
    byte_t h0, h1, h2, h3, h4, h5;
    logic [3:0] cls;
    h0 = hdr[7:0];
    h1 = hdr[15:8];
    h2 = hdr[23:16];
    h3 = hdr[31:24];
    h4 = hdr[39:32];
    h5 = hdr[47:40];
    cls = CLS_NONE;
    if (h0 == CH_DOLLAR) begin
      cls = CLS_UNKNOWN;
      if (h1 == "G" && h2 == "P") begin
        if (h3 == "G" && h4 == "G" && h5 == "A") cls = CLS_GGA;
        else if (h3 == "G" && h4 == "S" && h5 == "A") cls = CLS_GSA;
        else if (h3 == "G" && h4 == "S" && h5 == "V") cls = CLS_GSV;
        else if (h3 == "R" && h4 == "M" && h5 == "C") cls = CLS_RMC;
        else if (h3 == "V" && h4 == "T" && h5 == "G") cls = CLS_VTG;
      end else if (h1 == "P") begin
        if (h2 == "G" && h3 == "R" && h4 == "M" && h5 == "Z") cls = CLS_PGRMZ;
        else if (h2 == "M" && h3 == "T" && h4 == "K") cls = CLS_PMTK;
        else if (h2 == "S" && h3 == "C" && h4 == "S" && h5 == "O") cls = CLS_PSCSO;
        else if (h2 == "S" && h3 == "C" && h4 == "S" && h5 == "W") cls = CLS_PSCSW;
      end
    end else if (h0 == "O" && h1 == "K") begin
      cls = CLS_OK;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ----- design/line_fifo_with_sentence_classifier_core.sv -----
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[15:0]: one command transaction
// m_*      out  m_tvalid/m_tready  m_tdata[31:0]: one result transaction
//
// After rst drops, the byte store is swept to zero, one byte per cycle,
// all NBUF*BUF_DEPTH = 2560 bytes, with s_tready low.
// Commands in the bank pass ST_OP (one memory access for the operation),
// then six header reads in ST_PEEK on the same single memory port and
// ST_LAST for the last read data; a pop of a non-empty buffer also passes
// ST_POP for pop data. A channel outside the bank touches no buffer state.
// The result sits in an output register; a stalled m_tready holds at most
// one result there while the next command is already being worked.
`default_nettype none

module line_fifo_with_sentence_classifier_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func[1:0], channel[4:2], direction[5], data_byte[13:6], zero[15:14]
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // popped_byte[7:0], is_empty[8], byte_count[16:9], line_count[24:17],
  // head_class[28:25], status[29], zero[31:30]
  output logic      [31:0] m_tdata
);

  lfsc_pkg::item_t   item;
  lfsc_pkg::result_t res;
  logic              res_valid;
  logic              res_take;

  logic              mem_we;
  lfsc_pkg::addr_t   mem_addr;
  lfsc_pkg::byte_t   mem_wdata;
  lfsc_pkg::byte_t   mem_rdata;

  assign item = lfsc_pkg::item_t'(s_tdata[13:0]);

  // output slot is free when empty or being drained this cycle
  assign res_take = res_valid && (!m_tvalid || m_tready);

  lfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // all buffers share one byte store, buffer index in the upper address
  lfsc_ram #(
    .WIDTH (8),
    .DEPTH (lfsc_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule

`default_nettype wire

// ----- design/lfsc_ram.sv -----
`default_nettype none

module lfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- design/lfsc_ctrl.sv -----
`default_nettype none

module lfsc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire lfsc_pkg::item_t        in_item,
  output logic                        res_valid,
  input  wire logic                   res_take,
  output lfsc_pkg::result_t           res,
  output logic                        mem_we,
  output lfsc_pkg::addr_t             mem_addr,
  output lfsc_pkg::byte_t             mem_wdata,
  input  wire lfsc_pkg::byte_t        mem_rdata
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_OP    = 7'b0000100,
    ST_POP   = 7'b0001000,
    ST_PEEK  = 7'b0010000,
    ST_LAST  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  lfsc_pkg::ptr_t rp    [lfsc_pkg::NBUF];
  lfsc_pkg::ptr_t wp    [lfsc_pkg::NBUF];
  lfsc_pkg::ptr_t cnt   [lfsc_pkg::NBUF];
  lfsc_pkg::ptr_t lines [lfsc_pkg::NBUF];

  logic [1:0]         func_q;
  lfsc_pkg::buf_idx_t b_q;
  logic               dir_q;
  lfsc_pkg::byte_t    byte_q;
  logic               oor_q;
  lfsc_pkg::byte_t    popped;
  logic               status_q;
  lfsc_pkg::ptr_t     pk;
  logic [2:0]         k;
  logic [47:0]        hdr;
  lfsc_pkg::addr_t    clr_addr;

  lfsc_pkg::ptr_t  rp_c, wp_c, cnt_c, ln_c;
  lfsc_pkg::cnt1_t cnt_inc;
  logic            ovf;
  logic            in_oor;

  assign rp_c    = rp[b_q];
  assign wp_c    = wp[b_q];
  assign cnt_c   = cnt[b_q];
  assign ln_c    = lines[b_q];
  assign cnt_inc = lfsc_pkg::cnt1_t'({1'b0, cnt_c}) + lfsc_pkg::cnt1_t'(1);
  assign ovf     = cnt_inc >= lfsc_pkg::cnt1_t'(lfsc_pkg::BUF_DEPTH - 1);
  assign in_oor  = 32'(in_item.channel) >= 32'(lfsc_pkg::CHANNELS);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == lfsc_pkg::addr_t'(lfsc_pkg::MEM_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = in_oor ? ST_DONE : ST_OP;
      end
      ST_OP: begin
        state_next = (func_q == lfsc_pkg::FUNC_POP && cnt_c != '0) ? ST_POP : ST_PEEK;
      end
      ST_POP:  state_next = ST_PEEK;
      ST_PEEK: begin
        if (k == 3'(lfsc_pkg::PEEK_N - 1)) state_next = ST_LAST;
      end
      ST_LAST: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // single memory port: clearing sweep, push write, pop read, header peek
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_OP: begin
        if (func_q == lfsc_pkg::FUNC_PUSH) begin
          mem_we    = 1'b1;
          mem_addr  = lfsc_pkg::mem_addr(b_q, wp_c);
          mem_wdata = byte_q;
        end else begin
          mem_addr = lfsc_pkg::mem_addr(b_q, rp_c);
        end
      end
      ST_PEEK: mem_addr = lfsc_pkg::mem_addr(b_q, pk);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      k        <= '0;
      for (int i = 0; i < lfsc_pkg::NBUF; i++) begin
        rp[i]    <= '0;
        wp[i]    <= '0;
        cnt[i]   <= '0;
        lines[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr_addr <= lfsc_pkg::addr_t'(clr_addr + lfsc_pkg::addr_t'(1));
        ST_IDLE: begin
          if (in_valid) begin
            func_q   <= in_item.func;
            b_q      <= lfsc_pkg::buf_idx_t'({in_item.channel, in_item.direction});
            dir_q    <= in_item.direction;
            byte_q   <= in_item.data_byte;
            oor_q    <= in_oor;
            popped   <= '0;
            status_q <= 1'b0;
            k        <= '0;
          end
        end
        ST_OP: begin
          case (func_q)
            lfsc_pkg::FUNC_PUSH: begin
              if (ovf) begin
                rp[b_q]    <= '0;
                wp[b_q]    <= '0;
                cnt[b_q]   <= '0;
                lines[b_q] <= '0;
                status_q   <= 1'b1;
                pk         <= '0;
              end else begin
                cnt[b_q] <= cnt_inc[lfsc_pkg::PTR_W-1:0];
                wp[b_q]  <= lfsc_pkg::next_pos(wp_c);
                if (byte_q == lfsc_pkg::CH_NL && !dir_q) begin
                  lines[b_q] <= lfsc_pkg::ptr_t'(ln_c + lfsc_pkg::ptr_t'(1));
                end
                pk <= rp_c;
              end
            end
            lfsc_pkg::FUNC_CLEAR: begin
              rp[b_q]    <= '0;
              wp[b_q]    <= '0;
              cnt[b_q]   <= '0;
              lines[b_q] <= '0;
              pk         <= '0;
            end
            default: pk <= rp_c;
          endcase
        end
        ST_POP: begin
          popped   <= mem_rdata;
          cnt[b_q] <= lfsc_pkg::ptr_t'(cnt_c - lfsc_pkg::ptr_t'(1));
          if (mem_rdata == lfsc_pkg::CH_NL && ln_c != '0) begin
            lines[b_q] <= lfsc_pkg::ptr_t'(ln_c - lfsc_pkg::ptr_t'(1));
          end
          rp[b_q] <= lfsc_pkg::next_pos(rp_c);
          pk      <= lfsc_pkg::next_pos(rp_c);
        end
        ST_PEEK: begin
          pk <= lfsc_pkg::next_pos(pk);
          k  <= 3'(k + 3'd1);
          // read data comes back in the cycle after its address
          if (k != '0) hdr <= {mem_rdata, hdr[47:8]};
        end
        ST_LAST: hdr <= {mem_rdata, hdr[47:8]};
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (oor_q) begin
      res.popped_byte = '0;
      res.is_empty    = 1'b1;
      res.byte_count  = '0;
      res.line_count  = '0;
      res.head_class  = lfsc_pkg::CLS_NONE;
      res.status      = 1'b0;
    end else begin
      res.popped_byte = popped;
      res.is_empty    = (cnt_c == '0);
      res.byte_count  = lfsc_pkg::sat8(cnt_c);
      res.line_count  = lfsc_pkg::sat8(ln_c);
      res.head_class  = lfsc_pkg::classify(hdr);
      res.status      = status_q;
    end
  end

endmodule

`default_nettype wire

// ----- design/lfsc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module lfsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  logic unused_in;
  assign unused_in = ^s_tdata;

  `ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `ASSERT_RST(a_one_cmd, clk, rst, s_tvalid && s_tready |=> !s_tready, "second command taken while busy")
  `ASSERT_RST(a_empty_cnt, clk, rst, m_tvalid |-> (m_tdata[8] == (m_tdata[16:9] == 8'd0)), "empty flag disagrees with byte count")
  `ASSERT_RST(a_lines_le, clk, rst, m_tvalid |-> (m_tdata[24:17] <= m_tdata[16:9]), "more lines than bytes")
  `ASSERT_RST(a_ovf_clear, clk, rst, m_tvalid && m_tdata[29] |-> m_tdata[8] && (m_tdata[7:0] == 8'd0), "overflow left bytes")

endmodule

bind line_fifo_with_sentence_classifier_core lfsc_checker u_lfsc_checker (.*);

`default_nettype wire

// ----- tb/line_fifo_with_sentence_classifier_core_tb.sv -----
`timescale 1ns / 100ps

module line_fifo_with_sentence_classifier_core_tb;
  import lfsc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 20000; // covers the store sweep after reset
  localparam int TAIL_CYCLES    = 32;    // idle tail before the final report
  localparam int N_KNOWN        = 9;
  localparam int N_HEADS        = 15;

  localparam logic [1:0] FUNC_NOP = 2'd3; // unused code, must leave the buffer alone
  localparam logic       DIR_RX   = 1'b0;
  localparam logic       DIR_TX   = 1'b1;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  line_fifo_with_sentence_classifier_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // shadow copy of the buffer bank
  byte_t       shadow_mem [NBUF][BUF_DEPTH];
  int unsigned rd_ptr [NBUF];
  int unsigned wr_ptr [NBUF];
  int unsigned fill   [NBUF];
  int unsigned lines  [NBUF];

  result_t     pending_results [$];
  int unsigned items_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned idle_edges     = 0;

  // '?' matches any byte; the leading '$' is checked separately
  string      known_heads [N_KNOWN] = '{"$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG",
                                        "$PGRMZ", "$PMTK?", "$PSCSO", "$PSCSW"};
  logic [3:0] known_class [N_KNOWN] = '{CLS_GGA, CLS_GSA, CLS_GSV, CLS_RMC, CLS_VTG,
                                        CLS_PGRMZ, CLS_PMTK, CLS_PSCSO, CLS_PSCSW};
  string      sentence_heads [N_HEADS] = '{"$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG",
                                           "$PGRMZ", "$PMTK", "$PSCSO", "$PSCSW", "$GPXXX",
                                           "$PSCSX", "$QZ", "OK", "OX", "xyz"};

  // head of buffer: six bytes from the read pointer, stale bytes included
  function automatic logic [3:0] head_sentence_class(input int unsigned b);
    byte_t peek [6];
    bit    hit;
    int    i, k;
    for (i = 0; i < 6; i++) peek[i] = shadow_mem[b][(rd_ptr[b] + i) % BUF_DEPTH];
    if (peek[0] == CH_DOLLAR) begin
      for (k = 0; k < N_KNOWN; k++) begin
        hit = 1'b1;
        for (i = 1; i < 6; i++)
          if (known_heads[k][i] != "?" && known_heads[k][i] != peek[i]) hit = 1'b0;
        if (hit) return known_class[k];
      end
      return CLS_UNKNOWN;
    end
    if (peek[0] == "O" && peek[1] == "K") return CLS_OK;
    return CLS_NONE;
  endfunction

  function automatic void empty_buffer(input int unsigned b);
    rd_ptr[b] = 0;
    wr_ptr[b] = 0;
    fill[b]   = 0;
    lines[b]  = 0;
  endfunction

  // updates the shadow bank for one command and returns the result it should produce
  function automatic result_t apply_command(input item_t it);
    result_t     r;
    int unsigned b;
    r = '0;
    if (int'(it.channel) >= CHANNELS) begin
      r.is_empty = 1'b1;
      return r;
    end
    b = int'(it.channel) * 2 + int'(it.direction);
    case (it.func)
      FUNC_PUSH: begin
        shadow_mem[b][wr_ptr[b]] = it.data_byte;
        wr_ptr[b] = (wr_ptr[b] + 1) % BUF_DEPTH;
        fill[b]++;
        if (fill[b] >= BUF_DEPTH - 1) begin
          // overflow drops everything, the newline just pushed included
          empty_buffer(b);
          r.status = 1'b1;
        end else if (it.data_byte == CH_NL && it.direction == DIR_RX) begin
          lines[b]++;
        end
      end
      FUNC_POP: begin
        if (fill[b] != 0) begin
          r.popped_byte = shadow_mem[b][rd_ptr[b]];
          fill[b]--;
          if (r.popped_byte == CH_NL && lines[b] != 0) lines[b]--;
          rd_ptr[b] = (rd_ptr[b] + 1) % BUF_DEPTH;
        end
      end
      FUNC_CLEAR: empty_buffer(b);
      default: ;
    endcase
    r.is_empty   = (fill[b] == 0);
    r.byte_count = (fill[b] > 255) ? 8'hFF : 8'(fill[b]);
    r.line_count = (lines[b] > 255) ? 8'hFF : 8'(lines[b]);
    r.head_class = head_sentence_class(b);
    return r;
  endfunction

  function automatic void report_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    mismatches++;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result transaction with none expected, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.popped_byte !== want.popped_byte)
      report_field("popped_byte", want.popped_byte, got.popped_byte);
    if (got.is_empty !== want.is_empty)
      report_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
    if (got.byte_count !== want.byte_count)
      report_field("byte_count", want.byte_count, got.byte_count);
    if (got.line_count !== want.line_count)
      report_field("line_count", want.line_count, got.line_count);
    if (got.head_class !== want.head_class)
      report_field("head_class", 8'(want.head_class), 8'(got.head_class));
    if (got.status !== want.status)
      report_field("status", 8'(want.status), 8'(got.status));
  endtask

  // result side: check on accept, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(result_t'(m_tdata[29:0]));
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_edges <= 0;
    else idle_edges <= idle_edges + 1;
    if (idle_edges >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid is only dropped while idling, so back-to-back commands keep it high
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_command(it));
    items_sent++;
  endtask

  task automatic send_command(input logic [1:0] op, input int unsigned chan, input logic dir,
                              input byte_t data);
    item_t it;
    it.func      = op;
    it.channel   = 3'(chan);
    it.direction = dir;
    it.data_byte = data;
    send_item(it);
  endtask

  task automatic push_text(input int unsigned chan, input logic dir, input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_command(FUNC_PUSH, chan, dir, byte_t'(s[i]));
  endtask

  task automatic pop_bytes(input int unsigned chan, input logic dir, input int unsigned n);
    repeat (n) send_command(FUNC_POP, chan, dir, 8'($urandom));
  endtask

  // header, zero to five printable payload bytes, newline
  task automatic push_sentence(input int unsigned chan, input logic dir);
    push_text(chan, dir, sentence_heads[$urandom_range(N_HEADS - 1)]);
    repeat ($urandom_range(5)) send_command(FUNC_PUSH, chan, dir, 8'($urandom_range(126, 32)));
    send_command(FUNC_PUSH, chan, dir, CH_NL);
  endtask

  // sender holds off until the scoreboard has drained
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_out_of_range();
    send_command(FUNC_PUSH, 5, DIR_RX, 8'hA5);
    send_command(FUNC_POP, 6, DIR_TX, 8'h00);
    send_command(FUNC_NOP, 7, DIR_TX, 8'hFF);
  endtask

  task automatic test_basic_ops();
    send_command(FUNC_POP, CHANNELS - 1, DIR_TX, 8'h00);   // empty pop
    send_command(FUNC_PUSH, CHANNELS - 1, DIR_TX, 8'h00);
    send_command(FUNC_PUSH, CHANNELS - 1, DIR_TX, 8'hFF);
    send_command(FUNC_NOP, CHANNELS - 1, DIR_TX, 8'h5A);
    send_command(FUNC_POP, CHANNELS - 1, DIR_TX, 8'h00);
    send_command(FUNC_CLEAR, CHANNELS - 1, DIR_TX, 8'h00);
  endtask

  task automatic test_head_peek();
    push_text(1, DIR_RX, "OK");
    push_text(1, DIR_TX, "OX");                             // 'O' without 'K'
    push_text(2, DIR_RX, "$PMTK");                          // sixth byte unchecked
    send_command(FUNC_PUSH, 2, DIR_RX, CH_NL);
    send_command(FUNC_PUSH, 2, DIR_TX, CH_NL);              // tx newline is not a line
    send_command(FUNC_POP, 2, DIR_RX, 8'h00);
    send_command(FUNC_CLEAR, 2, DIR_RX, 8'h00);             // stale bytes still peeked
    send_command(FUNC_POP, 2, DIR_TX, 8'h00);               // newline with no line pending
  endtask

  // move the pointers off zero, then fill past the end so the write pointer
  // wraps, and overflow on a newline
  task automatic test_overflow_wrap();
    int unsigned chan, b;
    chan = $urandom_range(CHANNELS - 1);
    b    = chan * 2;
    while (fill[b] < 100) push_sentence(chan, DIR_RX);
    pop_bytes(chan, DIR_RX, fill[b]);
    while (fill[b] < 240) push_sentence(chan, DIR_RX);
    while (fill[b] < BUF_DEPTH - 2)
      send_command(FUNC_PUSH, chan, DIR_RX, 8'($urandom_range(126, 32)));
    send_command(FUNC_PUSH, chan, DIR_RX, CH_NL);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at, pick, chan;
    logic        dir;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      chan = $urandom_range(CHANNELS - 1);
      dir  = ($urandom_range(99) < 70) ? DIR_RX : DIR_TX;
      if (pick < 45) push_sentence(chan, dir);
      else if (pick < 80) pop_bytes(chan, dir, $urandom_range(16, 1));
      else if (pick < 84) send_command(FUNC_CLEAR, chan, dir, 8'($urandom));
      else if (pick < 92) send_command(FUNC_PUSH, chan, dir, 8'($urandom));
      else send_item(item_t'(14'($urandom)));   // any field values, bad channels included
    end
  endtask

  initial begin
    int b, p;
    for (b = 0; b < NBUF; b++) begin
      empty_buffer(b);
      for (p = 0; p < BUF_DEPTH; p++) shadow_mem[b][p] = 8'h00;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_out_of_range();
    test_basic_ops();
    test_head_peek();
    test_overflow_wrap();
    wait_all_results();

    src_idle_pct = 85;
    test_random_traffic(130);
    wait_all_results();

    src_idle_pct   = 0;
    sink_stall_pct = 85;
    test_random_traffic(130);
    wait_all_results();

    src_idle_pct   = 8;
    sink_stall_pct = 8;
    test_random_traffic(140);
    wait_all_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
